// ===== src/html_content_sniffer_assert.svh =====
// ----------------------------------------------------------------------------
// html_content_sniffer assertion macros
// Shorthands for clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HTML_CONTENT_SNIFFER_ASSERT_SVH
`define HTML_CONTENT_SNIFFER_ASSERT_SVH

// same-cycle implication
`define HCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define HCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/hcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hcs_pkg
// Scan modes, character constants and scanner state type for the sniffer.
// ----------------------------------------------------------------------------
package hcs_pkg;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_TAG    = 3'd1;
   localparam logic [2:0] MODE_SKIP   = 3'd2;
   localparam logic [2:0] MODE_SLASH  = 3'd3;
   localparam logic [2:0] MODE_LINE   = 3'd4;
   localparam logic [2:0] MODE_BLOCK  = 3'd5;
   localparam logic [2:0] MODE_ESCAPE = 3'd6;
   localparam logic [2:0] MODE_STOP   = 3'd7;

   localparam logic [2:0] TAG_LEN = 3'd4;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   // upper-case letters of the tag name, indexed by match position
   localparam logic [7:0] TAG_UPPER [4] = '{8'h48, 8'h54, 8'h4D, 8'h4C};

   typedef struct packed {
      logic [2:0] scan_mode;
      logic [2:0] tag_match_pos;
      logic [7:0] closing_char;
      logic       star_seen;
      logic       html_found;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      scan_mode:     MODE_NORMAL,
      tag_match_pos: 3'd0,
      closing_char:  CH_NUL,
      star_seen:     1'b0,
      html_found:    1'b0
   };

endpackage

// ===== src/hcs_step.sv =====
// ----------------------------------------------------------------------------
// hcs_step
// Combinational next-state logic of the scanner for one body byte.
// ----------------------------------------------------------------------------
module hcs_step (
   input  hcs_pkg::scan_state_type cur_state,
   input  logic [7:0]              text_byte,
   input  logic                    body_end,
   output hcs_pkg::scan_state_type nxt_state,
   output logic                    is_html
);

   hcs_pkg::scan_state_type upd;
   logic [7:0] tag_up;

   // dispatch of a nonzero byte in normal scanning
   function automatic hcs_pkg::scan_state_type normal_dispatch(
      input hcs_pkg::scan_state_type st,
      input logic [7:0]              b
   );
      hcs_pkg::scan_state_type r;
      r = st;
      case (b) inside
         hcs_pkg::CH_LT: begin
            r.scan_mode     = hcs_pkg::MODE_TAG;
            r.tag_match_pos = 3'd0;
         end
         hcs_pkg::CH_SQUOTE, hcs_pkg::CH_DQUOTE, hcs_pkg::CH_LPAREN,
         hcs_pkg::CH_LBRACK, hcs_pkg::CH_LBRACE: begin
            r.scan_mode    = hcs_pkg::MODE_SKIP;
            r.closing_char = b;
         end
         hcs_pkg::CH_SLASH:  r.scan_mode = hcs_pkg::MODE_SLASH;
         hcs_pkg::CH_BSLASH: r.scan_mode = hcs_pkg::MODE_ESCAPE;
         default: ;
      endcase
      return r;
   endfunction

   assign tag_up = hcs_pkg::TAG_UPPER[cur_state.tag_match_pos[1:0]];

   always_comb begin
      upd = cur_state;
      if (text_byte == hcs_pkg::CH_NUL) begin
         upd.scan_mode = hcs_pkg::MODE_STOP;
      end else begin
         case (cur_state.scan_mode)
            hcs_pkg::MODE_NORMAL: upd = normal_dispatch(cur_state, text_byte);
            hcs_pkg::MODE_TAG: begin
               if (cur_state.tag_match_pos < hcs_pkg::TAG_LEN) begin
                  if (text_byte == tag_up ||
                      text_byte == (tag_up | hcs_pkg::CASE_BIT)) begin
                     upd.tag_match_pos = cur_state.tag_match_pos + 3'd1;
                  end else if (text_byte == hcs_pkg::CH_GT) begin
                     upd.scan_mode = hcs_pkg::MODE_NORMAL;
                  end else begin
                     upd.scan_mode    = hcs_pkg::MODE_SKIP;
                     upd.closing_char = hcs_pkg::CH_GT;
                  end
               end else if (text_byte == hcs_pkg::CH_SPACE ||
                            text_byte == hcs_pkg::CH_GT ||
                            text_byte == hcs_pkg::CH_SLASH ||
                            text_byte == hcs_pkg::CH_LF) begin
                  upd.html_found = 1'b1;
                  upd.scan_mode  = hcs_pkg::MODE_STOP;
               end else begin
                  upd.scan_mode    = hcs_pkg::MODE_SKIP;
                  upd.closing_char = hcs_pkg::CH_GT;
               end
            end
            hcs_pkg::MODE_SKIP: begin
               if (text_byte == cur_state.closing_char) begin
                  upd.scan_mode = hcs_pkg::MODE_NORMAL;
               end
            end
            hcs_pkg::MODE_SLASH: begin
               if (text_byte == hcs_pkg::CH_SLASH) begin
                  upd.scan_mode = hcs_pkg::MODE_LINE;
               end else if (text_byte == hcs_pkg::CH_STAR) begin
                  upd.scan_mode = hcs_pkg::MODE_BLOCK;
                  upd.star_seen = 1'b1;
               end else begin
                  upd.scan_mode = hcs_pkg::MODE_NORMAL;
                  upd = normal_dispatch(upd, text_byte);
               end
            end
            hcs_pkg::MODE_LINE: begin
               if (text_byte == hcs_pkg::CH_LF || text_byte == hcs_pkg::CH_CR) begin
                  upd.scan_mode = hcs_pkg::MODE_NORMAL;
               end
            end
            hcs_pkg::MODE_BLOCK: begin
               // the opening star counts, so "/*/" closes at once
               if (cur_state.star_seen && text_byte == hcs_pkg::CH_SLASH) begin
                  upd.scan_mode = hcs_pkg::MODE_NORMAL;
                  upd.star_seen = 1'b0;
               end else begin
                  upd.star_seen = (text_byte == hcs_pkg::CH_STAR);
               end
            end
            hcs_pkg::MODE_ESCAPE: upd.scan_mode = hcs_pkg::MODE_NORMAL;
            default: ;
         endcase
      end
   end

   assign is_html   = upd.html_found;
   assign nxt_state = body_end ? hcs_pkg::SCAN_RESET : upd;

endmodule

// ===== src/html_content_sniffer.sv =====
// ----------------------------------------------------------------------------
// html_content_sniffer
// Byte-serial HTML opening-tag detector with a registered result per body.
// ----------------------------------------------------------------------------
// The body's last byte is registered in the byte stage, and its result then in the result register.
// Throughput: one byte per cycle while the byte stage is not held; the scan state updates once per byte.
// A stalled result holds the byte stage only when that byte also ends a body.
// Reset: synchronous; clears the byte stage, the result register and the
// scanner state to normal scanning.
module html_content_sniffer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_body_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_html
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_html_ff;
   logic       s1_go;
   logic       step_html;

   hcs_pkg::scan_state_type state_ff, state_in;

   hcs_step u_step (
      .cur_state (state_ff),
      .text_byte (in_byte_ff),
      .body_end  (in_end_ff),
      .nxt_state (state_in),
      .is_html   (step_html)
   );

   // the byte stage moves unless it ends a body while the result is stuck
   assign s1_go     = in_valid_ff && !(in_end_ff && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !s1_go;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !s1_go);
   assign out_valid_in = (s1_go && in_end_ff) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hcs_pkg::SCAN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
         in_end_ff  <= req_body_end;
      end
      if (s1_go && in_end_ff) begin
         out_html_ff <= step_html;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_is_html = out_html_ff;

`include "html_content_sniffer_assert.svh"

   `HCS_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, out_valid_ff && rsp_stall && in_end_ff)
   `HCS_ASSERT_NXT(a_end_clears, clock, reset, s1_go && in_end_ff, state_ff == hcs_pkg::SCAN_RESET)
   `HCS_ASSERT_NXT(a_end_result, clock, reset, s1_go && in_end_ff, rsp_valid)
   `HCS_ASSERT_IMP(a_found_stops, clock, reset, state_ff.html_found, state_ff.scan_mode == hcs_pkg::MODE_STOP)

endmodule

// ===== sim/html_content_sniffer_test.sv =====
// ----------------------------------------------------------------------------
// html_content_sniffer_test
// Streams content bodies byte by byte into the sniffer, predicts the per-body
// answer with an independent scanner model and checks every result in order.
// ----------------------------------------------------------------------------
module html_content_sniffer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LONG_HOLD_CYCLES = 200;
   localparam int unsigned PRESSURE_BURST   = 60;
   localparam int unsigned TEXT_TARGET      = 1950;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
      logic       pressure_start;  // wait for drain, then hold the receiver off
   } text_item_type;

   typedef enum int unsigned {
      TOK_HTML_TAG,
      TOK_PARTIAL_TAG,
      TOK_OTHER_TAG,
      TOK_QUOTED,
      TOK_LINE_COMMENT,
      TOK_BLOCK_COMMENT,
      TOK_ESCAPE,
      TOK_SLASH,
      TOK_WORD,
      TOK_RANDOM
   } token_kind_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_body_end  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_is_html;

   text_item_type text_bytes_pending[$];
   logic          expected_is_html[$];
   logic [7:0]    body_text[$];
   int unsigned   mismatch_count = 0;

   // scanner prediction state
   logic [2:0] mode_now;
   logic [2:0] letters_matched;
   logic [7:0] skip_close;
   logic       after_star;
   logic       tag_seen;

   html_content_sniffer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_body_end  (req_body_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_html   (rsp_is_html)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void clear_scanner();
      mode_now        = hcs_pkg::MODE_NORMAL;
      letters_matched = 3'd0;
      skip_close      = hcs_pkg::CH_NUL;
      after_star      = 1'b0;
      tag_seen        = 1'b0;
   endfunction

   function automatic void scan_plain_byte(input logic [7:0] b);
      case (b)
         hcs_pkg::CH_LT: begin
            mode_now        = hcs_pkg::MODE_TAG;
            letters_matched = 3'd0;
         end
         hcs_pkg::CH_SQUOTE, hcs_pkg::CH_DQUOTE, hcs_pkg::CH_LPAREN,
         hcs_pkg::CH_LBRACK, hcs_pkg::CH_LBRACE: begin
            mode_now   = hcs_pkg::MODE_SKIP;
            skip_close = b;
         end
         hcs_pkg::CH_SLASH:  mode_now = hcs_pkg::MODE_SLASH;
         hcs_pkg::CH_BSLASH: mode_now = hcs_pkg::MODE_ESCAPE;
         default: ;
      endcase
   endfunction

   function automatic void abandon_tag(input logic [7:0] b);
      if (b == hcs_pkg::CH_GT) begin
         mode_now = hcs_pkg::MODE_NORMAL;
      end else begin
         mode_now   = hcs_pkg::MODE_SKIP;
         skip_close = hcs_pkg::CH_GT;
      end
   endfunction

   function automatic void scan_tag_byte(input logic [7:0] b);
      logic [7:0] up;
      if (letters_matched < hcs_pkg::TAG_LEN) begin
         up = hcs_pkg::TAG_UPPER[letters_matched[1:0]];
         if (b == up || b == (up | hcs_pkg::CASE_BIT))
            letters_matched = letters_matched + 3'd1;
         else
            abandon_tag(b);
      end else if (b == hcs_pkg::CH_SPACE || b == hcs_pkg::CH_GT ||
                   b == hcs_pkg::CH_SLASH || b == hcs_pkg::CH_LF) begin
         tag_seen = 1'b1;
         mode_now = hcs_pkg::MODE_STOP;
      end else begin
         abandon_tag(b);
      end
   endfunction

   function automatic void sniff_byte(input logic [7:0] b, input logic last,
                                      output logic answered, output logic answer);
      if (b == hcs_pkg::CH_NUL) begin
         mode_now = hcs_pkg::MODE_STOP;
      end else begin
         case (mode_now)
            hcs_pkg::MODE_NORMAL: scan_plain_byte(b);
            hcs_pkg::MODE_TAG:    scan_tag_byte(b);
            hcs_pkg::MODE_SKIP:   if (b == skip_close) mode_now = hcs_pkg::MODE_NORMAL;
            hcs_pkg::MODE_SLASH: begin
               if (b == hcs_pkg::CH_SLASH) begin
                  mode_now = hcs_pkg::MODE_LINE;
               end else if (b == hcs_pkg::CH_STAR) begin
                  mode_now   = hcs_pkg::MODE_BLOCK;
                  after_star = 1'b1;
               end else begin
                  mode_now = hcs_pkg::MODE_NORMAL;
                  scan_plain_byte(b);
               end
            end
            hcs_pkg::MODE_LINE: begin
               if (b == hcs_pkg::CH_LF || b == hcs_pkg::CH_CR)
                  mode_now = hcs_pkg::MODE_NORMAL;
            end
            hcs_pkg::MODE_BLOCK: begin
               if (after_star && b == hcs_pkg::CH_SLASH) begin
                  mode_now   = hcs_pkg::MODE_NORMAL;
                  after_star = 1'b0;
               end else begin
                  after_star = (b == hcs_pkg::CH_STAR);
               end
            end
            hcs_pkg::MODE_ESCAPE: mode_now = hcs_pkg::MODE_NORMAL;
            default: ;
         endcase
      end
      answered = last;
      answer   = tag_seen;
      if (last)
         clear_scanner();
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic int unsigned pick_gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_text_byte();
      if ($urandom_range(0, 4) != 0)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic append_string(input string s);
      for (int i = 0; i < s.len(); i++)
         body_text.push_back(s[i]);
   endtask

   task automatic push_tag_start(input int unsigned letters);
      body_text.push_back(hcs_pkg::CH_LT);
      for (int i = 0; i < letters; i++)
         body_text.push_back(hcs_pkg::TAG_UPPER[2'(i)] |
                             ($urandom_range(0, 1) ? hcs_pkg::CASE_BIT : 8'h00));
   endtask

   task automatic push_html_tag();
      int unsigned r;
      push_tag_start(4);
      r = $urandom_range(0, 4);
      case (r)
         0: body_text.push_back(hcs_pkg::CH_SPACE);
         1: body_text.push_back(hcs_pkg::CH_GT);
         2: body_text.push_back(hcs_pkg::CH_SLASH);
         3: body_text.push_back(hcs_pkg::CH_LF);
         default: body_text.push_back(rand_text_byte());
      endcase
   endtask

   // filler text whose random bytes avoid the byte that would end the skip (an added HTML tag may still hold it)
   task automatic push_content(input logic [7:0] avoid);
      int unsigned n;
      logic [7:0]  b;
      n = $urandom_range(0, 6);
      repeat (n) begin
         b = rand_text_byte();
         if (b == avoid) b = 8'h61;
         body_text.push_back(b);
      end
      if ($urandom_range(0, 3) == 0)
         push_html_tag();
   endtask

   task automatic add_token();
      token_kind_type kind;
      logic [7:0]     opener;
      int unsigned    n;
      kind = token_kind_type'($urandom_range(0, TOK_RANDOM));
      case (kind)
         TOK_HTML_TAG:    push_html_tag();
         TOK_PARTIAL_TAG: begin
            push_tag_start($urandom_range(0, 3));
            body_text.push_back(rand_text_byte());
         end
         TOK_OTHER_TAG: begin
            body_text.push_back(hcs_pkg::CH_LT);
            n = $urandom_range(1, 5);
            repeat (n) body_text.push_back(8'($urandom_range(8'h61, 8'h7A)));
            body_text.push_back(hcs_pkg::CH_GT);
         end
         TOK_QUOTED: begin
            case ($urandom_range(0, 4))
               0: opener = hcs_pkg::CH_SQUOTE;
               1: opener = hcs_pkg::CH_DQUOTE;
               2: opener = hcs_pkg::CH_LPAREN;
               3: opener = hcs_pkg::CH_LBRACK;
               default: opener = hcs_pkg::CH_LBRACE;
            endcase
            body_text.push_back(opener);
            push_content(opener);
            if ($urandom_range(0, 9) != 0) body_text.push_back(opener);
         end
         TOK_LINE_COMMENT: begin
            append_string("//");
            push_content(hcs_pkg::CH_LF);
            if ($urandom_range(0, 9) != 0)
               body_text.push_back($urandom_range(0, 1) ? hcs_pkg::CH_LF : hcs_pkg::CH_CR);
         end
         TOK_BLOCK_COMMENT: begin
            append_string("/*");
            if ($urandom_range(0, 3) == 0) begin
               body_text.push_back(hcs_pkg::CH_SLASH);  // star of the opener closes it
            end else begin
               push_content(hcs_pkg::CH_SLASH);
               if ($urandom_range(0, 2) == 0) body_text.push_back(hcs_pkg::CH_STAR);
               if ($urandom_range(0, 9) != 0) append_string("*/");
            end
         end
         TOK_ESCAPE: begin
            body_text.push_back(hcs_pkg::CH_BSLASH);
            body_text.push_back($urandom_range(0, 1) ? hcs_pkg::CH_LT : rand_text_byte());
         end
         TOK_SLASH: begin
            body_text.push_back(hcs_pkg::CH_SLASH);
            body_text.push_back($urandom_range(0, 1) ? hcs_pkg::CH_LT : rand_text_byte());
         end
         TOK_WORD: begin
            n = $urandom_range(1, 8);
            repeat (n) body_text.push_back(rand_text_byte());
         end
         default: body_text.push_back(8'($urandom_range(1, 255)));
      endcase
   endtask

   task automatic send_body(input logic pressure);
      text_item_type item;
      for (int i = 0; i < body_text.size(); i++) begin
         item.text           = body_text[i];
         item.last           = (i == body_text.size() - 1);
         item.pressure_start = pressure && (i == 0);
         text_bytes_pending.push_back(item);
      end
      body_text.delete();
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      int unsigned body_count;
      int unsigned n;

      // directed bodies
      append_string("<hTmL>");
      body_text.push_back(8'hFF);        // ignored once the tag is found
      send_body(1'b0);
      body_text.push_back(hcs_pkg::CH_NUL);
      send_body(1'b0);
      append_string("/<htm");            // slash then a tag opener, cut-off tag
      send_body(1'b0);
      append_string("\\");
      send_body(1'b0);
      append_string("/");
      send_body(1'b0);
      append_string("/*/<html ");        // block comment closed by its own star
      send_body(1'b0);

      body_count = 0;
      while (text_bytes_pending.size() < TEXT_TARGET) begin
         if (body_count == 25 || body_count == 80) begin
            body_text.push_back(rand_text_byte());
            send_body(1'b1);
            repeat (24) begin
               n = $urandom_range(1, 3);
               repeat (n) body_text.push_back(rand_text_byte());
               send_body(1'b0);
            end
         end
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) body_text.push_back(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) add_token();
            if ($urandom_range(0, 24) == 0) begin
               body_text.push_back(hcs_pkg::CH_NUL);
               add_token();
            end
         end
         send_body(1'b0);
         body_count++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (text_bytes_pending.size() != 0 || req_valid) @(posedge clock);
      while (expected_is_html.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   text_item_type next_item;
   int unsigned   send_gap_left;
   int unsigned   burst_left;
   logic          long_hold_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_text_byte <= 8'h00;
         req_body_end  <= 1'b0;
         send_gap_left <= 0;
         burst_left    <= 0;
         long_hold_req <= 1'b0;
      end else begin
         long_hold_req <= 1'b0;
         if (!req_valid || !req_stall) begin
            if (send_gap_left != 0) begin
               send_gap_left <= send_gap_left - 1;
               req_valid     <= 1'b0;
            end else if (text_bytes_pending.size() != 0 &&
                         !(text_bytes_pending[0].pressure_start &&
                           (req_valid || expected_is_html.size() != 0))) begin
               next_item = text_bytes_pending.pop_front();
               req_valid     <= 1'b1;
               req_text_byte <= next_item.text;
               req_body_end  <= next_item.last;
               if (next_item.pressure_start) begin
                  long_hold_req <= 1'b1;
                  burst_left    <= PRESSURE_BURST;
                  send_gap_left <= 0;
               end else if (burst_left != 0) begin
                  burst_left    <= burst_left - 1;
                  send_gap_left <= 0;
               end else if ($urandom_range(0, 63) == 0) begin
                  burst_left    <= $urandom_range(20, 80);
                  send_gap_left <= 0;
               end else begin
                  send_gap_left <= pick_gap_length();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   int unsigned stall_left;
   int unsigned open_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         open_left  <= 0;
      end else if (long_hold_req) begin
         rsp_stall  <= 1'b1;
         stall_left <= LONG_HOLD_CYCLES;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (open_left != 0) begin
         rsp_stall  <= 1'b0;
         open_left  <= open_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         open_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(0, 12);
         stall_left <= pick_gap_length();
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic note_mismatch(input string what, input logic want, input logic got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %0b, got %0b", $time, what, want, got);
   endtask

   logic answered;
   logic answer;
   logic want_html;

   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
      end else begin
         if (req_valid && !req_stall) begin
            sniff_byte(req_text_byte, req_body_end, answered, answer);
            if (answered)
               expected_is_html.push_back(answer);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_is_html.size() == 0) begin
               note_mismatch("is_html transaction with nothing expected", 1'bx, rsp_is_html);
            end else begin
               want_html = expected_is_html.pop_front();
               if (rsp_is_html !== want_html)
                  note_mismatch("is_html mismatch", want_html, rsp_is_html);
            end
         end
      end
   end

endmodule

// ===== sim.f =====
+incdir+src
src/hcs_pkg.sv
src/hcs_step.sv
src/html_content_sniffer.sv
sim/html_content_sniffer_test.sv
